[rtl/mlpf_pkg.sv]
package mlpf_pkg;

    // Default configuration
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int STATE_BITS_DEF  = 32;

    // Fixed-point format: state and coefficients carry 24 fraction bits
    localparam int FRAC     = 24;
    localparam int HALF_LSB = 1 << (FRAC - 1);

    // Coefficient operand width of the shared multiplier
    localparam int C_W = 28;

    localparam logic signed [C_W-1:0] ONE_Q   = C_W'(16777216);
    localparam logic signed [C_W-1:0] K_0P8   = C_W'(13421773);
    localparam logic signed [C_W-1:0] K_5P6   = C_W'(93952410);
    localparam logic signed [C_W-1:0] K_0P5   = C_W'(8388608);
    localparam logic signed [C_W-1:0] K_SIXTH = C_W'(2796208);
    localparam logic signed [C_W-1:0] K_BMAX  = C_W'(23726565);

    // Input clamps
    localparam logic [15:0] CUT_MAX = 16'd65470;
    localparam logic [16:0] RES_MAX = 17'd65536;

    // Sequencer steps: one product per step, then output formatting
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_T0,
        ST_P,
        ST_T1,
        ST_INNER,
        ST_T2,
        ST_T3,
        ST_QQ,
        ST_FB,
        ST_A1,
        ST_N1,
        ST_A2,
        ST_N2,
        ST_A3,
        ST_N3,
        ST_A4,
        ST_N4,
        ST_C1,
        ST_C2,
        ST_C3,
        ST_DIFF,
        ST_SCALE,
        ST_EMIT
    } step_t;

    // Phases of one rounded product on the shared multiplier
    typedef enum logic [1:0] {
        PH_LOAD,
        PH_LO,
        PH_HI,
        PH_DONE
    } phase_t;

endpackage

[rtl/moog_ladder_lowpass_filter.sv]
// Four-pole resonant ladder lowpass. Each item carries one Q1.15 sample with
// its cutoff (Q0.16, clamped to 0.999) and resonance (Q0.16, 65536 = one).
// The block derives p, f and q, subtracts the resonance feedback, runs four
// one-pole stages, clamps the fourth to +-sqrt(2) and soft-clips it with
// y - y^3/6, then returns lowpass, highpass and bandpass, each saturated to
// the sample width. All products go through a single 25x28 multiplier: each
// of the 19 rounded products passes through operand load, low half, high
// half and accumulate, and the DIFF, SCALE and EMIT steps then form the
// outputs. in_stall is high while an item is in work; a finished result
// waits in the output register and the next item is accepted, but that item
// waits in its EMIT step while the earlier result is still stalled.
module moog_ladder_lowpass_filter #(
    parameter int SAMPLE_BITS = mlpf_pkg::SAMPLE_BITS_DEF,
    parameter int STATE_BITS  = mlpf_pkg::STATE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [SAMPLE_BITS-1:0] sample_in,
    input  logic        [15:0]            cutoff,
    input  logic        [16:0]            resonance,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [SAMPLE_BITS-1:0] lowpass,
    output logic signed [SAMPLE_BITS-1:0] highpass,
    output logic signed [SAMPLE_BITS-1:0] bandpass
);
    import mlpf_pkg::*;

    // Working widths
    localparam int WW      = STATE_BITS + 4;
    localparam int MUL_A_W = (WW - FRAC > FRAC + 1) ? WW - FRAC : FRAC + 1;
    localparam int PW      = MUL_A_W + C_W;
    localparam int RW      = PW + 1;
    localparam int TW      = (WW + 1 > 48) ? WW + 1 : 48;

    // Sample <-> state alignment
    localparam int SH      = FRAC - (SAMPLE_BITS - 1);
    localparam int SH_L    = (SH > 0) ? SH : 0;
    localparam int SH_R    = (SH < 0) ? -SH : 0;
    localparam int RND_IN  = (SH_R > 0) ? (1 << (SH_R - 1)) : 0;
    localparam int RND_OUT = (SH_L > 0) ? (1 << (SH_L - 1)) : 0;

    localparam logic signed [RW-1:0] ST_MAX_R =
        {{(RW - STATE_BITS + 1){1'b0}}, {(STATE_BITS - 1){1'b1}}};
    localparam logic signed [RW-1:0] ST_MIN_R =
        {{(RW - STATE_BITS + 1){1'b1}}, {(STATE_BITS - 1){1'b0}}};
    localparam logic signed [TW-1:0] S40_MAX = {{(TW - 39){1'b0}}, {39{1'b1}}};
    localparam logic signed [TW-1:0] S40_MIN = {{(TW - 39){1'b1}}, {39{1'b0}}};
    localparam logic signed [TW-1:0] SMP_MAX =
        {{(TW - SAMPLE_BITS + 1){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
    localparam logic signed [TW-1:0] SMP_MIN =
        {{(TW - SAMPLE_BITS + 1){1'b1}}, {(SAMPLE_BITS - 1){1'b0}}};

    // Sample to state format
    function automatic logic signed [WW-1:0] from_sample(
        input logic signed [SAMPLE_BITS-1:0] s
    );
        logic signed [SAMPLE_BITS:0] r;
        r = (SAMPLE_BITS + 1)'(s) + (SAMPLE_BITS + 1)'(RND_IN);
        if (SH_R == 0)
        begin
            return WW'(s) <<< SH_L;
        end
        return WW'(r >>> SH_R);
    endfunction

    // State to sample format, rounded and saturated
    function automatic logic [SAMPLE_BITS-1:0] to_sample(
        input logic signed [WW-1:0] v
    );
        logic signed [TW-1:0] r;
        logic signed [TW-1:0] w;
        w = TW'(v);
        if (SH_L > 0)
        begin
            r = (w + TW'(RND_OUT)) >>> SH_L;
        end
        else if (SH_R == 0)
        begin
            r = w;
        end
        else
        begin
            if (w > S40_MAX)
            begin
                w = S40_MAX;
            end
            else if (w < S40_MIN)
            begin
                w = S40_MIN;
            end
            r = w <<< SH_R;
        end
        if (r > SMP_MAX)
        begin
            r = SMP_MAX;
        end
        else if (r < SMP_MIN)
        begin
            r = SMP_MIN;
        end
        return r[SAMPLE_BITS-1:0];
    endfunction

    // Saturate to the state range
    function automatic logic signed [STATE_BITS-1:0] sat_state(
        input logic signed [RW-1:0] v
    );
        if (v > ST_MAX_R)
        begin
            return ST_MAX_R[STATE_BITS-1:0];
        end
        if (v < ST_MIN_R)
        begin
            return ST_MIN_R[STATE_BITS-1:0];
        end
        return v[STATE_BITS-1:0];
    endfunction

    // Control
    step_t  step_reg, step_next;
    phase_t phase_reg, phase_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;
    logic   is_mul;

    // Latched item
    logic signed [SAMPLE_BITS-1:0] samp_reg;
    logic        [15:0]            cut_reg;
    logic        [16:0]            res_reg;

    // Coefficients and temporaries
    logic signed [C_W-1:0] p_reg;
    logic signed [C_W-1:0] inner_reg;
    logic signed [C_W-1:0] qq_reg;
    logic signed [WW-1:0]  t_reg;

    // New state values of this item
    logic signed [STATE_BITS-1:0] x_reg, n1_reg, n2_reg, n3_reg;
    logic signed [WW-1:0]         n4_reg;

    // Filter state
    logic signed [STATE_BITS-1:0] prev_reg, s1_reg, s2_reg, s3_reg;
    logic signed [WW-1:0]         s4_reg;

    // Output formatting
    logic signed [WW-1:0] hp_reg, bp_reg;
    logic [SAMPLE_BITS-1:0] lp_out_reg, hp_out_reg, bp_out_reg;

    // Shared multiplier datapath
    logic signed [WW-1:0]      a_reg, a_sel;
    logic signed [C_W-1:0]     c_reg, c_sel;
    logic signed [RW-1:0]      base_sel;
    logic                      sub_sel;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [PW-1:0]      mul_res;
    logic signed [PW-1:0]      prod_reg;
    logic signed [PW-1:0]      frac_w;
    logic signed [RW-1:0]      acc_reg;
    logic signed [RW-1:0]      res_w;

    // Derived coefficients
    logic signed [WW-1:0]  fr_w;
    logic signed [C_W-1:0] q1_w;
    logic signed [C_W-1:0] f_w;

    assign fr_w = WW'($signed({1'b0, cut_reg, {(FRAC - 16){1'b0}}}));
    assign q1_w = ONE_Q - C_W'(fr_w);
    assign f_w  = (p_reg <<< 1) - ONE_Q;

    assign out_free = !out_valid_reg || !out_stall;
    assign is_mul   = (step_reg != ST_IDLE) && (step_reg != ST_DIFF) &&
                      (step_reg != ST_SCALE) && (step_reg != ST_EMIT);

    // Next state
    always_comb
    begin
        step_next  = step_reg;
        phase_next = phase_reg;
        if (is_mul)
        begin
            unique case (phase_reg)
                PH_LOAD: phase_next = PH_LO;
                PH_LO:   phase_next = PH_HI;
                PH_HI:   phase_next = PH_DONE;
                PH_DONE: phase_next = PH_LOAD;
                default: phase_next = PH_LOAD;
            endcase
        end
        unique case (step_reg)
            ST_IDLE:
            begin
                phase_next = PH_LOAD;
                if (in_valid)
                begin
                    step_next = ST_T0;
                end
            end
            ST_DIFF:  step_next = ST_SCALE;
            ST_SCALE: step_next = ST_EMIT;
            ST_EMIT:
            begin
                if (out_free)
                begin
                    step_next = ST_IDLE;
                end
            end
            default:
            begin
                if (phase_reg == PH_DONE)
                begin
                    step_next = step_t'(step_reg + 5'd1);
                end
            end
        endcase
    end

    // Outputs of the sequencer: operand, base and sign selection
    always_comb
    begin
        in_stall = (step_reg != ST_IDLE);
        a_sel    = t_reg;
        c_sel    = p_reg;
        base_sel = '0;
        sub_sel  = 1'b0;
        unique case (step_reg)
            ST_T0:
            begin
                a_sel = fr_w;
                c_sel = K_0P8;
            end
            ST_P:
            begin
                c_sel    = q1_w;
                base_sel = RW'(fr_w);
            end
            ST_T1:
            begin
                a_sel = WW'(q1_w);
                c_sel = K_5P6;
            end
            ST_INNER:
            begin
                c_sel    = q1_w;
                base_sel = RW'(fr_w);
            end
            ST_T2:
            begin
                a_sel = WW'(q1_w);
                c_sel = K_0P5;
            end
            ST_T3:
            begin
                c_sel    = inner_reg;
                base_sel = RW'(ONE_Q);
            end
            ST_QQ:
            begin
                a_sel = WW'($signed({1'b0, res_reg, {(FRAC - 16){1'b0}}}));
                c_sel = t_reg[C_W-1:0];
            end
            ST_FB:
            begin
                a_sel    = s4_reg;
                c_sel    = qq_reg;
                base_sel = RW'(from_sample(samp_reg));
                sub_sel  = 1'b1;
            end
            ST_A1: a_sel = WW'(x_reg) + WW'(prev_reg);
            ST_A2: a_sel = WW'(n1_reg) + WW'(s1_reg);
            ST_A3: a_sel = WW'(n2_reg) + WW'(s2_reg);
            ST_A4: a_sel = WW'(n3_reg) + WW'(s3_reg);
            ST_N1, ST_N2, ST_N3, ST_N4:
            begin
                unique case (step_reg)
                    ST_N1:   a_sel = WW'(s1_reg);
                    ST_N2:   a_sel = WW'(s2_reg);
                    ST_N3:   a_sel = WW'(s3_reg);
                    default: a_sel = s4_reg;
                endcase
                c_sel    = f_w;
                base_sel = RW'(t_reg);
                sub_sel  = 1'b1;
            end
            ST_C1:
            begin
                a_sel = n4_reg;
                c_sel = n4_reg[C_W-1:0];
            end
            ST_C2: c_sel = n4_reg[C_W-1:0];
            ST_C3:
            begin
                c_sel    = K_SIXTH;
                base_sel = RW'(n4_reg);
                sub_sel  = 1'b1;
            end
            default:
            begin
                a_sel = t_reg;
            end
        endcase
    end

    // Shared multiplier: low 24 bits of a first, then the high part
    assign mul_a   = (phase_reg == PH_LO) ?
                     MUL_A_W'($signed({1'b0, a_reg[FRAC-1:0]})) :
                     MUL_A_W'($signed(a_reg[WW-1:FRAC]));
    assign mul_res = mul_a * c_reg;
    assign frac_w  = (prod_reg + PW'(HALF_LSB)) >>> FRAC;
    assign res_w   = sub_sel ? (acc_reg - RW'(prod_reg)) : (acc_reg + RW'(prod_reg));

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= ST_IDLE;
            phase_reg     <= PH_LOAD;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output handshake
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (step_reg == ST_EMIT && out_free)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Filter state, committed once the item's new values are complete
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg <= '0;
            s1_reg   <= '0;
            s2_reg   <= '0;
            s3_reg   <= '0;
            s4_reg   <= '0;
        end
        else if (step_reg == ST_DIFF)
        begin
            prev_reg <= x_reg;
            s1_reg   <= n1_reg;
            s2_reg   <= n2_reg;
            s3_reg   <= n3_reg;
            s4_reg   <= n4_reg;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        // Latch and clamp the item
        if (step_reg == ST_IDLE && in_valid)
        begin
            samp_reg <= sample_in;
            cut_reg  <= (cutoff > CUT_MAX) ? CUT_MAX : cutoff;
            res_reg  <= (resonance > RES_MAX) ? RES_MAX : resonance;
        end

        // Rounded product: load, low half, high half, accumulate
        if (is_mul)
        begin
            unique case (phase_reg)
                PH_LOAD:
                begin
                    a_reg <= a_sel;
                    c_reg <= c_sel;
                end
                PH_LO:
                begin
                    prod_reg <= mul_res;
                end
                PH_HI:
                begin
                    acc_reg  <= sub_sel ? (base_sel - RW'(frac_w)) :
                                          (base_sel + RW'(frac_w));
                    prod_reg <= mul_res;
                end
                PH_DONE:
                begin
                    unique case (step_reg)
                        ST_P:     p_reg     <= res_w[C_W-1:0];
                        ST_INNER: inner_reg <= res_w[C_W-1:0];
                        ST_QQ:    qq_reg    <= res_w[C_W-1:0];
                        ST_FB:    x_reg     <= sat_state(res_w);
                        ST_N1:    n1_reg    <= sat_state(res_w);
                        ST_N2:    n2_reg    <= sat_state(res_w);
                        ST_N3:    n3_reg    <= sat_state(res_w);
                        ST_N4:
                        begin
                            // fourth stage clamped to +-sqrt(2)
                            if (res_w > RW'(K_BMAX))
                            begin
                                n4_reg <= WW'(K_BMAX);
                            end
                            else if (res_w < -RW'(K_BMAX))
                            begin
                                n4_reg <= -WW'(K_BMAX);
                            end
                            else
                            begin
                                n4_reg <= res_w[WW-1:0];
                            end
                        end
                        ST_C3:    n4_reg    <= res_w[WW-1:0];
                        default:  t_reg     <= res_w[WW-1:0];
                    endcase
                end
                default:
                begin
                    a_reg <= a_sel;
                end
            endcase
        end

        // Output formatting
        if (step_reg == ST_DIFF)
        begin
            hp_reg <= WW'(x_reg) - n4_reg;
            bp_reg <= WW'(n3_reg) - n4_reg;
        end
        if (step_reg == ST_SCALE)
        begin
            bp_reg <= bp_reg + (bp_reg <<< 1);
        end
        if (step_reg == ST_EMIT && out_free)
        begin
            lp_out_reg <= to_sample(n4_reg);
            hp_out_reg <= to_sample(hp_reg);
            bp_out_reg <= to_sample(bp_reg);
        end
    end

    assign out_valid = out_valid_reg;
    assign lowpass   = $signed(lp_out_reg);
    assign highpass  = $signed(hp_out_reg);
    assign bandpass  = $signed(bp_out_reg);

endmodule

[dv/moog_ladder_lowpass_filter_test.sv]
module moog_ladder_lowpass_filter_test;

    // Q8.24 arithmetic shared by the ladder predictor
    localparam int     FRAC_BITS  = 24;
    localparam longint Q_ONE      = longint'(1) <<< FRAC_BITS;
    localparam longint Q_HALF     = longint'(1) <<< (FRAC_BITS - 1);
    localparam longint C_0P8      = 13421773;
    localparam longint C_5P6      = 93952410;
    localparam longint C_0P5      = 8388608;
    localparam longint C_SIXTH    = 2796208;
    localparam longint C_SQRT2    = 23726565;
    localparam longint STATE_HI   = (longint'(1) <<< 31) - 1;
    localparam longint STATE_LO   = -STATE_HI - 1;
    localparam logic [15:0] CUTOFF_LIMIT = 16'd65470;
    localparam logic [16:0] RESO_LIMIT   = 17'd65536;

    localparam int IDLE_LIMIT = 3000;
    localparam int DRAIN_CYCLES = 100;

    typedef struct packed {
        logic signed [15:0] lp;
        logic signed [15:0] hp;
        logic signed [15:0] bp;
    } ladder_out_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic signed [15:0] sample_in = '0;
    logic [15:0] cutoff = '0;
    logic [16:0] resonance = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [15:0] lowpass;
    logic signed [15:0] highpass;
    logic signed [15:0] bandpass;

    // Predicted filter state
    longint ladder_prev_in;
    longint ladder_s1;
    longint ladder_s2;
    longint ladder_s3;
    longint ladder_s4;

    ladder_out_t filter_out_q[$];
    int fail_count = 0;
    int burst_left = 0;
    int idle_cycles = 0;

    // Receiver stall pattern bookkeeping
    int stall_mode = 0;
    int stall_mode_left = 0;
    int stall_hold_left = 0;

    moog_ladder_lowpass_filter u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .sample_in (sample_in),
        .cutoff    (cutoff),
        .resonance (resonance),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .lowpass   (lowpass),
        .highpass  (highpass),
        .bandpass  (bandpass)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // a * c / 2^24, rounded with ties toward +inf
    function automatic longint round_mul(longint a, longint c);
        longint hi;
        longint lo;
        hi = a >>> FRAC_BITS;
        lo = a - (hi <<< FRAC_BITS);
        return hi * c + ((lo * c + Q_HALF) >>> FRAC_BITS);
    endfunction

    function automatic longint clamp_state(longint v);
        if (v > STATE_HI)
            return STATE_HI;
        if (v < STATE_LO)
            return STATE_LO;
        return v;
    endfunction

    // Q8.24 -> Q1.15 with rounding and saturation
    function automatic logic signed [15:0] to_q15(longint v);
        longint r;
        r = (v + 256) >>> 9;
        if (r > 32767)
            r = 32767;
        else if (r < -32768)
            r = -32768;
        return r[15:0];
    endfunction

    // One ladder step: coefficients, feedback, four poles, soft clip
    function automatic ladder_out_t predict_ladder(logic signed [15:0] s, logic [15:0] c,
                                                   logic [16:0] r);
        logic [15:0] cut_c;
        logic [16:0] res_c;
        longint fr, q1, p, f, inner, qq, x, n1, n2, n3, n4;
        ladder_out_t o;
        cut_c = (c > CUTOFF_LIMIT) ? CUTOFF_LIMIT : c;
        res_c = (r > RESO_LIMIT) ? RESO_LIMIT : r;

        fr = longint'(cut_c) <<< 8;
        q1 = Q_ONE - fr;
        p = fr + round_mul(round_mul(fr, C_0P8), q1);
        f = p + p - Q_ONE;
        inner = Q_ONE - q1 + round_mul(round_mul(q1, C_5P6), q1);
        qq = round_mul(longint'(res_c) <<< 8, Q_ONE + round_mul(round_mul(q1, C_0P5), inner));

        x = clamp_state((longint'(s) <<< 9) - round_mul(ladder_s4, qq));
        n1 = clamp_state(round_mul(x + ladder_prev_in, p) - round_mul(ladder_s1, f));
        n2 = clamp_state(round_mul(n1 + ladder_s1, p) - round_mul(ladder_s2, f));
        n3 = clamp_state(round_mul(n2 + ladder_s2, p) - round_mul(ladder_s3, f));
        n4 = round_mul(n3 + ladder_s3, p) - round_mul(ladder_s4, f);
        if (n4 > C_SQRT2)
            n4 = C_SQRT2;
        else if (n4 < -C_SQRT2)
            n4 = -C_SQRT2;
        n4 = n4 - round_mul(round_mul(round_mul(n4, n4), n4), C_SIXTH);

        ladder_prev_in = x;
        ladder_s1 = n1;
        ladder_s2 = n2;
        ladder_s3 = n3;
        ladder_s4 = n4;

        o.lp = to_q15(n4);
        o.hp = to_q15(x - n4);
        o.bp = to_q15(3 * (n3 - n4));
        return o;
    endfunction

    // Send one item; the sender runs in bursts separated by random gaps
    task automatic send_item(input logic signed [15:0] s, input logic [15:0] c,
                             input logic [16:0] r);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 10);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 100);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        in_valid  <= 1'b1;
        sample_in <= s;
        cutoff    <= c;
        resonance <= r;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        filter_out_q.push_back(predict_ladder(s, c, r));
        burst_left--;
    endtask

    // Full-scale corners, clamp thresholds and output overflow
    task automatic test_directed_extremes();
        send_item(16'sd0, 16'd0, 17'd0);
        repeat (3) send_item(16'sd32767, 16'd65535, 17'd131071);
        repeat (3) send_item(-16'sd32768, 16'd65535, 17'd131071);
        send_item(16'sd32767, 16'd65470, 17'd65536);
        send_item(-16'sd32768, 16'd65471, 17'd65537);
        send_item(16'sd0, 16'd0, 17'd65536);
        send_item(16'sd32767, 16'd0, 17'd131071);
        send_item(-16'sd32768, 16'd1, 17'd0);
        send_item(16'sh5555, 16'hAAAA, 17'h0AAAA);
        send_item(16'shAAAA, 16'h5555, 17'h15555);
        send_item(-16'sd1, 16'd65535, 17'd0);
        send_item(16'sd1, 16'd32768, 17'd32768);
    endtask

    // Loud square waves right around the cutoff and resonance clamps
    task automatic test_clamp_boundaries();
        int period;
        logic signed [15:0] s;
        period = $urandom_range(1, 8);
        for (int k = 0; k < 80; k++)
        begin
            if ($urandom_range(0, 4) == 0)
                s = 16'($urandom);
            else
                s = ((k / period) % 2) ? 16'sd32767 : -16'sd32768;
            send_item(s, 16'($urandom_range(65466, 65535)),
                      ($urandom_range(0, 9) == 0) ? 17'd131071
                                                  : 17'($urandom_range(65532, 65540)));
        end
    endtask

    // Segments with settings held and structured content
    task automatic test_held_settings();
        int seg_len;
        int shape;
        int period;
        logic [15:0] amp;
        logic [15:0] c;
        logic [16:0] r;
        logic signed [15:0] s;
        for (int seg = 0; seg < 20; seg++)
        begin
            seg_len = $urandom_range(10, 30);
            shape = $urandom_range(0, 3);
            period = $urandom_range(1, 12);
            amp = 16'($urandom_range(0, 32767));
            case ($urandom_range(0, 2))
                0: c = 16'($urandom_range(0, 2000));
                1: c = 16'($urandom_range(0, 65535));
                default: c = 16'($urandom_range(60000, 65535));
            endcase
            if ($urandom_range(0, 7) == 0)
                r = 17'($urandom_range(65537, 131071));
            else
                r = 17'($urandom_range(0, 65536));
            for (int k = 0; k < seg_len; k++)
            begin
                case (shape)
                    0: s = ((k / period) % 2) ? amp : ~amp;
                    1: s = 16'($urandom);
                    2: s = (k == 0) ? amp : 16'sd0;
                    default: s = 16'(k * 2731 - 32768);
                endcase
                send_item(s, c, r);
            end
        end
    endtask

    // Every field random on every item
    task automatic test_random_fields();
        for (int k = 0; k < 200; k++)
            send_item(16'($urandom), 16'($urandom_range(0, 65535)),
                      17'($urandom_range(0, 131071)));
    endtask

    // Receiver stall: runs of no stall, random stall, and long holds
    always @(posedge clk)
    begin
        if (stall_mode_left == 0)
        begin
            stall_mode = $urandom_range(0, 2);
            stall_mode_left = $urandom_range(50, 400);
        end
        stall_mode_left--;
        if (stall_mode == 0)
            out_stall <= 1'b0;
        else if (stall_mode == 1)
            out_stall <= ($urandom_range(0, 2) == 0);
        else if (stall_hold_left == 0)
        begin
            stall_hold_left = $urandom_range(1, 150);
            out_stall <= ~out_stall;
        end
        else
            stall_hold_left--;
    end

    // Compare each accepted result with the oldest prediction
    always @(posedge clk)
    begin
        ladder_out_t exp_out;
        if (rst_n && out_valid && !out_stall)
        begin
            if (filter_out_q.size() == 0)
            begin
                $display("%0t unexpected result: lp %0d hp %0d bp %0d",
                         $time, lowpass, highpass, bandpass);
                fail_count++;
            end
            else
            begin
                exp_out = filter_out_q.pop_front();
                if (lowpass !== exp_out.lp)
                begin
                    $display("%0t lowpass: expected %0d, got %0d", $time, exp_out.lp, lowpass);
                    fail_count++;
                end
                if (highpass !== exp_out.hp)
                begin
                    $display("%0t highpass: expected %0d, got %0d", $time, exp_out.hp,
                             highpass);
                    fail_count++;
                end
                if (bandpass !== exp_out.bp)
                begin
                    $display("%0t bandpass: expected %0d, got %0d", $time, exp_out.bp,
                             bandpass);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog on cycles with no item moving on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        ladder_prev_in = 0;
        ladder_s1 = 0;
        ladder_s2 = 0;
        ladder_s3 = 0;
        ladder_s4 = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_extremes();
        test_clamp_boundaries();
        test_held_settings();
        test_random_fields();
        in_valid <= 1'b0;

        // drain outstanding results, then watch for strays
        while (filter_out_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
